[design/dqe_pkg.sv]
// Package for the DNS QNAME label encoder: sizes, codes, FSM type,
// chain control struct and the saturating count helper. No dependencies.
`default_nettype none
package dqe_pkg;

  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 63;
  localparam int TAIL_LEN    = 5;
  localparam int CHAIN_DEPTH = STORE_DEPTH + TAIL_LEN;
  localparam int IDX_W       = $clog2(CHAIN_DEPTH + 1);
  localparam int TAIL_W      = $clog2(TAIL_LEN);
  localparam int CNT_W       = 10;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [7:0]       DOT_CHAR  = 8'h2E;
  localparam logic [7:0]       TERM_BYTE = 8'h00;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic REG_QTYPE  = 1'b0;
  localparam logic REG_QCLASS = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr_char;
    logic wr_tail;
    logic shift1;
    logic shift2;
  } chain_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/dqe_cell.sv]
// One byte cell of the label chain: direct load or shift by one or two.
// No dependencies; instantiated by dqe_chain.
`default_nettype none
module dqe_cell (
  input  wire logic       clk,
  input  wire logic       load_en,
  input  wire logic [7:0] load_data,
  input  wire logic       shift1,
  input  wire logic       shift2,
  input  wire logic [7:0] nb1_data,
  input  wire logic [7:0] nb2_data,
  output logic      [7:0] data
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load_en) begin
      data_nxt = load_data;
    end else if (shift2) begin
      data_nxt = nb2_data;
    end else if (shift1) begin
      data_nxt = nb1_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

[design/dqe_chain.sv]
// Row of dqe_cell instances holding the current label and trailer bytes.
// Depends on dqe_pkg and dqe_cell. Head bytes are cells 0 and 1.
`default_nettype none
module dqe_chain (
  input  wire logic                       clk,
  input  wire dqe_pkg::chain_ctrl_t       ctrl,
  input  wire logic [dqe_pkg::IDX_W-1:0]  base,
  input  wire logic [7:0]                 char_data,
  input  wire logic [dqe_pkg::TAIL_LEN-1:0][7:0] tail_data,
  output logic      [7:0]                 head0,
  output logic      [7:0]                 head1
);
  import dqe_pkg::*;

  logic [CHAIN_DEPTH+1:0][7:0] cell_q;

  assign cell_q[CHAIN_DEPTH]   = 8'h00;
  assign cell_q[CHAIN_DEPTH+1] = 8'h00;

  for (genvar i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
    logic [IDX_W-1:0] off;
    logic             ld;
    logic [7:0]       ld_data;

    always_comb begin
      off     = IDX_W'(i) - base;
      ld      = 1'b0;
      ld_data = char_data;
      if (ctrl.wr_char && off == '0 && i < STORE_DEPTH) begin
        ld = 1'b1;
      end else if (ctrl.wr_tail && off < IDX_W'(TAIL_LEN)) begin
        ld      = 1'b1;
        ld_data = tail_data[off[TAIL_W-1:0]];
      end
    end

    dqe_cell u_cell (
      .clk      (clk),
      .load_en  (ld),
      .load_data(ld_data),
      .shift1   (ctrl.shift1),
      .shift2   (ctrl.shift2),
      .nb1_data (cell_q[i+1]),
      .nb2_data (cell_q[i+2]),
      .data     (cell_q[i])
    );
  end

  assign head0 = cell_q[0];
  assign head1 = cell_q[1];

endmodule
`default_nettype wire

[design/dns_qname_label_encoder_unit.sv]
// Top level of the DNS QNAME label encoder: control FSM, counters, config
// registers and output register. Depends on dqe_pkg, dqe_chain, dqe_cell.
//
//  channel  | dir | handshake         | payload
//  in_      | in  | tvalid/tready     | tdata = ch, tuser = op
//  out_     | out | tvalid/tready     | tdata/tuser/tlast, one transaction per byte pair
//  cfg_     | in  | we                | addr = register index, wdata = value
//
// A character transaction is stored in the chain, or sets the overflow flag
// when the label is full. A dot or end transaction starts a run of output
// pairs: ceil((L+1)/2) for a dot, ceil((L+6)/2) for end, L the buffered label
// length; after the first pair the chain shifts two bytes per pair. Output stalls
// hold the chain; input is refused while pairs are being emitted. Reset is synchronous.
`default_nettype none
module dns_qname_label_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic        in_tuser,   // [0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [7:0] first_byte, [15:8] second_byte,
                                       // [16] label_error, [26:17] qname_bytes,
                                       // [36:27] question_bytes, [39:37] zero
  output logic             out_tuser,  // [0] second_valid
  output logic             out_tlast,  // run_last
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import dqe_pkg::*;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   name_cnt_r, name_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [15:0]        qtype_r, qclass_r;
  logic [IDX_W-1:0]   rem_r, rem_nxt;
  logic               first_r, first_nxt;
  logic [7:0]         lenbyte_r, lenbyte_nxt;
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   qn_r, qn_nxt, qs_r, qs_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         ob0_r, ob1_r, ob0_nxt, ob1_nxt;
  logic               osv_r, osv_nxt, olast_r, olast_nxt, oerr_r, oerr_nxt;
  logic [CNT_W-1:0]   oqn_r, oqs_r, oqn_nxt, oqs_nxt;

  chain_ctrl_t        ctrl;
  logic [7:0]         head0, head1;
  logic [TAIL_LEN-1:0][7:0] tail;
  logic               in_fire, emit_fire;
  logic [CNT_W-1:0]   rel_n, qn_calc;

  assign tail = {qclass_r[7:0], qclass_r[15:8], qtype_r[7:0], qtype_r[15:8], TERM_BYTE};

  dqe_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .base     (len_r),
    .char_data(in_tdata),
    .tail_data(tail),
    .head0    (head0),
    .head1    (head1)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    name_cnt_nxt = name_cnt_r;
    ovf_nxt      = ovf_r;
    rem_nxt      = rem_r;
    first_nxt    = first_r;
    lenbyte_nxt  = lenbyte_r;
    err_nxt      = err_r;
    qn_nxt       = qn_r;
    qs_nxt       = qs_r;
    ctrl         = '0;
    rel_n        = CNT_W'(len_r) + CNT_W'(1);
    qn_calc      = sat_add(name_cnt_r, rel_n + CNT_W'(1));

    out_valid_nxt = out_valid_r && !out_tready;
    ob0_nxt   = ob0_r;
    ob1_nxt   = ob1_r;
    osv_nxt   = osv_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;
    oqn_nxt   = oqn_r;
    oqs_nxt   = oqs_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_CHAR && in_tdata != DOT_CHAR) begin
            if (len_r < IDX_W'(MAX_LABEL)) begin
              ctrl.wr_char = 1'b1;
              len_nxt      = len_r + IDX_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            lenbyte_nxt = 8'(len_r);
            first_nxt   = 1'b1;
            err_nxt     = ovf_r;
            len_nxt     = '0;
            state_nxt   = ST_EMIT;
            if (in_tuser == OP_END) begin
              ctrl.wr_tail = 1'b1;
              rem_nxt      = len_r + IDX_W'(TAIL_LEN);
              qn_nxt       = qn_calc;
              qs_nxt       = sat_add(qn_calc, CNT_W'(4));
              name_cnt_nxt = '0;
              ovf_nxt      = 1'b0;
            end else begin
              rem_nxt      = len_r;
              qn_nxt       = '0;
              qs_nxt       = '0;
              name_cnt_nxt = sat_add(name_cnt_r, rel_n);
            end
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          oerr_nxt      = err_r;
          oqn_nxt       = qn_r;
          oqs_nxt       = qs_r;
          first_nxt     = 1'b0;
          if (first_r) begin
            ob0_nxt   = lenbyte_r;
            osv_nxt   = (rem_r != '0);
            ob1_nxt   = (rem_r != '0) ? head0 : 8'h00;
            olast_nxt = (rem_r <= IDX_W'(1));
            if (rem_r != '0) begin
              ctrl.shift1 = 1'b1;
              rem_nxt     = rem_r - IDX_W'(1);
            end
          end else begin
            ob0_nxt   = head0;
            osv_nxt   = (rem_r >= IDX_W'(2));
            ob1_nxt   = (rem_r >= IDX_W'(2)) ? head1 : 8'h00;
            olast_nxt = (rem_r <= IDX_W'(2));
            if (rem_r >= IDX_W'(2)) begin
              ctrl.shift2 = 1'b1;
              rem_nxt     = rem_r - IDX_W'(2);
            end else begin
              ctrl.shift1 = 1'b1;
              rem_nxt     = '0;
            end
          end
          if (olast_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      name_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      qtype_r     <= 16'd1;
      qclass_r    <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      name_cnt_r  <= name_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_QTYPE:  qtype_r  <= cfg_wdata;
          REG_QCLASS: qclass_r <= cfg_wdata;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    first_r   <= first_nxt;
    lenbyte_r <= lenbyte_nxt;
    err_r     <= err_nxt;
    qn_r      <= qn_nxt;
    qs_r      <= qs_nxt;
    ob0_r     <= ob0_nxt;
    ob1_r     <= ob1_nxt;
    osv_r     <= osv_nxt;
    olast_r   <= olast_nxt;
    oerr_r    <= oerr_nxt;
    oqn_r     <= oqn_nxt;
    oqs_r     <= oqs_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, oqs_r, oqn_r, oerr_r, ob1_r, ob0_r};
  assign out_tuser  = osv_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

[test/tb_dns_qname_label_encoder_unit.sv]
// Testbench for dns_qname_label_encoder_unit: streams dotted names, predicts the
// encoded question section pairs and checks every output transaction.
// Depends on dqe_pkg and the encoder RTL.
`timescale 1ns / 100ps
module tb_dns_qname_label_encoder_unit;
  import dqe_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       run_last;
    logic       label_error;
    logic [9:0] qname_bytes;
    logic [9:0] question_bytes;
  } byte_pair_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_addr;
  logic [15:0] cfg_wdata;

  // encoder model state
  logic [7:0]  label_buf [0:62];
  int          label_len = 0;
  logic [9:0]  name_count = '0;
  logic        label_ovf = 1'b0;
  logic [15:0] qtype_reg = 16'd1;
  logic [15:0] qclass_reg = 16'd1;

  byte_pair_t  pair_q [$];
  byte_pair_t  want;
  int          fail_cnt = 0;
  int          sent_cnt = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  dns_qname_label_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [9:0] count_add(input logic [9:0] a, input int b);
    int s;
    s = int'(a) + b;
    return (s > int'(COUNT_MAX)) ? COUNT_MAX : s[9:0];
  endfunction

  // one input transaction -> zero or more expected byte pairs
  task automatic encode_item(input logic op, input logic [7:0] ch);
    logic [7:0] bytes [$];
    logic [9:0] qn;
    logic [9:0] qs;
    byte_pair_t p;
    int i;
    if (op == OP_CHAR && ch != DOT_CHAR) begin
      if (label_len < MAX_LABEL) begin
        label_buf[label_len] = ch;
        label_len++;
      end else begin
        label_ovf = 1'b1;
      end
      return;
    end
    bytes.push_back(8'(label_len));
    for (i = 0; i < label_len; i++) bytes.push_back(label_buf[i]);
    label_len = 0;
    if (op == OP_CHAR) begin
      name_count = count_add(name_count, bytes.size());
      qn = '0;
      qs = '0;
    end else begin
      bytes.push_back(TERM_BYTE);
      qn = count_add(name_count, bytes.size());
      qs = count_add(qn, 4);
      bytes.push_back(qtype_reg[15:8]);
      bytes.push_back(qtype_reg[7:0]);
      bytes.push_back(qclass_reg[15:8]);
      bytes.push_back(qclass_reg[7:0]);
    end
    for (i = 0; i < bytes.size(); i += 2) begin
      p.first_byte     = bytes[i];
      p.second_valid   = (i + 1) < bytes.size();
      p.second_byte    = p.second_valid ? bytes[i+1] : 8'h00;
      p.run_last       = (i + 2) >= bytes.size();
      p.label_error    = label_ovf;
      p.qname_bytes    = qn;
      p.question_bytes = qs;
      pair_q.push_back(p);
    end
    if (op == OP_END) begin
      name_count = '0;
      label_ovf  = 1'b0;
    end
  endtask

  task automatic check_field(input string fname, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  // output checker, then input monitor; results never share an edge with their cause
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pair_q.size() == 0) begin
          $error("output transaction with no pair expected");
          fail_cnt++;
        end else begin
          want = pair_q.pop_front();
          check_field("first_byte", want.first_byte, out_tdata[7:0]);
          check_field("second_byte", want.second_byte, out_tdata[15:8]);
          check_field("second_valid", want.second_valid, out_tuser);
          check_field("run_last", want.run_last, out_tlast);
          check_field("label_error", want.label_error, out_tdata[16]);
          check_field("qname_bytes", want.qname_bytes, out_tdata[26:17]);
          check_field("question_bytes", want.question_bytes, out_tdata[36:27]);
        end
      end
      if (in_tvalid && in_tready) encode_item(in_tuser, in_tdata);
    end
  end

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    while (idle_on && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pair_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] qtype, input logic [15:0] qclass);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_QTYPE;
    cfg_wdata <= qtype;
    @(posedge clk);
    qtype_reg = qtype;
    cfg_addr  <= REG_QCLASS;
    cfg_wdata <= qclass;
    @(posedge clk);
    qclass_reg = qclass;
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == DOT_CHAR) ? 8'h2D : c;
  endfunction

  task automatic send_label(input int len);
    int i;
    for (i = 0; i < len; i++) send_item(OP_CHAR, rand_char());
  endtask

  task automatic send_random_name();
    int nlab;
    int len;
    int j;
    if ($urandom_range(6) == 0) begin
      // noise: loose characters and dots, maybe a stray end
      repeat ($urandom_range(1, 12))
        send_item($urandom_range(9) == 0 ? OP_END : OP_CHAR,
                  $urandom_range(3) == 0 ? DOT_CHAR : 8'($urandom_range(255)));
      send_item(OP_END, 8'($urandom_range(255)));
      return;
    end
    nlab = $urandom_range(1, 4);
    for (j = 0; j < nlab; j++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 10);
      send_label(len);
      if (j < nlab - 1) send_item(OP_CHAR, DOT_CHAR);
    end
    if ($urandom_range(7) == 0) send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_END, 8'($urandom_range(255)));
  endtask

  task automatic run_random_names(input int n_items);
    int stop_at;
    int names;
    stop_at = sent_cnt + n_items;
    names = 0;
    while (sent_cnt < stop_at) begin
      send_random_name();
      names++;
      if (names % 4 == 0) write_config(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_basic_name();
    send_item(OP_CHAR, 8'h61);
    send_item(OP_CHAR, 8'h62);
    send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_CHAR, 8'h63);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_empty_labels();
    send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_CHAR, 8'h78);
    send_item(OP_END, DOT_CHAR);
    send_item(OP_END, 8'h55);
    send_item(OP_CHAR, 8'h79);
    send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_END, 8'hAA);
  endtask

  task automatic test_extreme_chars();
    write_config(16'h0000, 16'hFFFF);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, 8'h2D);
    send_item(OP_CHAR, DOT_CHAR);
    send_item(OP_CHAR, 8'h7F);
    send_item(OP_CHAR, 8'h80);
    send_item(OP_END, 8'hFF);
  endtask

  task automatic test_label_overflow();
    write_config(16'hFFFF, 16'h0000);
    send_label(63);
    send_item(OP_END, 8'h00);
    send_label(65);
    send_item(OP_CHAR, DOT_CHAR);
    send_label(2);
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_random_traffic();
    write_config(16'($urandom), 16'($urandom));
    run_random_names(80);
  endtask

  task automatic test_no_idle_stretch();
    wait_drain();
    idle_on = 1'b0;
    run_random_names(80);
    wait_drain();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= OP_CHAR;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_QTYPE;
    cfg_wdata <= 16'h0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_name();
    test_empty_labels();
    test_extreme_chars();
    test_label_overflow();
    test_random_traffic();
    test_no_idle_stretch();

    wait_drain();
    repeat (16) @(posedge clk);
    if (fail_cnt == 0 && pair_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
